>>> hw/rtl/wsetok_pkg.sv
package wsetok_pkg;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_WORD = 2'd1,
		MODE_STR  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		KIND_WORD_CHAR    = 4'd0,
		KIND_STRING_CHAR  = 4'd1,
		KIND_IDENT_END    = 4'd2,
		KIND_KEYWORD_END  = 4'd3,
		KIND_STRING_END   = 4'd4,
		KIND_EQUALS       = 4'd5,
		KIND_UNKNOWN      = 4'd6,
		KIND_EOF          = 4'd7,
		KIND_UNTERMINATED = 4'd8,
		KIND_TOO_LONG     = 4'd9
	} kind_t;

	localparam int unsigned LEN_W = 12;
	localparam logic [LEN_W-1:0] LEN_MAX = 12'd4095;
	localparam logic [LEN_W-1:0] KEYWORD_LEN = 12'd6;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	// keyword "export", one byte per position
	localparam logic [7:0] KEYWORD [6] = '{8'h65, 8'h78, 8'h70, 8'h6F, 8'h72, 8'h74};

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       value;
		logic [LEN_W-1:0] len;
		logic             last;
	} res_t;

	function automatic res_t mk_res(kind_t k, logic [7:0] v, logic [LEN_W-1:0] l);
		res_t r;
		r.kind = k;
		r.value = v;
		r.len = l;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

>>> hw/rtl/word_string_equals_tokenizer.sv
// word, string and equals tokenizer
//
// input channel s_*: one request per text byte (s_tuser[0] = 0, byte in
// s_tdata[7:0]) or an end-of-text request (s_tuser[0] = 1). whitespace is
// skipped, '=' gives an equals token, words stream their characters and
// close with identifier or keyword end, quoted strings stream their bytes.
// output channel m_*: token kind in m_tuser, byte and token length in
// m_tdata, m_tlast on the last result caused by one input request.
//
// each request is decoded in the cycle it is accepted against the mode
// register; its zero, one or two results are registered into a four-entry
// result queue that drives m_*. throughput is one request per cycle while
// requests give at most one result each and the receiver takes every
// result; a request that gives two results (word closed by another token,
// end of text after an open token) adds two queue entries.
// s_tready is high while the queue has two free entries, so the input keeps
// flowing while a finished result waits; when the receiver stalls the queue
// fills and s_tready drops. reset empties the queue and returns to idle.
module word_string_equals_tokenizer #(
	parameter int unsigned MAX_WORD_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] ch
	input  logic [0:0]  s_tuser,  // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [7:0] value, [19:8] token_length, [23:20] zero
	output logic [3:0]  m_tuser,  // [3:0] kind
	output logic        m_tlast
);

	localparam int unsigned LW = wsetok_pkg::LEN_W;

	// decoder state
	wsetok_pkg::mode_t mode_q, mode_d;
	logic [LW-1:0]     run_q, run_d;
	logic              kw_q, kw_d;

	// result queue
	wsetok_pkg::res_t fifo_q [4];
	logic [1:0]       wr_ptr_q, rd_ptr_q;
	logic [2:0]       count_q;

	wsetok_pkg::res_t res [2];
	logic [1:0]       n_res;

	logic       func;
	logic [7:0] c;
	logic       is_space, is_alpha, is_digit;
	logic       in_word;

	// word byte step
	logic [LW-1:0] wb_p, wb_run;
	logic          wb_match, wb_kw, wb_long;
	wsetok_pkg::res_t wb_res;
	wsetok_pkg::mode_t wb_mode;

	// idle byte handling
	logic             idle_emit;
	wsetok_pkg::res_t idle_res;
	wsetok_pkg::mode_t idle_mode;
	logic [LW-1:0]    idle_run;
	logic             idle_kw;

	wsetok_pkg::res_t close_res;

	logic accept, pop;

	assign func = s_tuser[0];
	assign c = s_tdata;
	assign is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	assign is_alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	assign is_digit = (c >= 8'h30 && c <= 8'h39);
	assign in_word = (mode_q == wsetok_pkg::MODE_WORD);

	// one word byte, either continuing the open word or starting a new one
	always_comb begin
		wb_p = in_word ? run_q : '0;
		wb_match = (wb_p < wsetok_pkg::KEYWORD_LEN) && (c == wsetok_pkg::KEYWORD[wb_p[2:0]]);
		wb_kw = (in_word ? kw_q : 1'b1) & wb_match;
		wb_run = wb_p + 1'b1;
		wb_long = (wb_run >= LW'(MAX_WORD_LEN));
		if (wb_long) begin
			wb_res = wsetok_pkg::mk_res(wsetok_pkg::KIND_TOO_LONG, 8'd0, wb_run);
			wb_mode = wsetok_pkg::MODE_IDLE;
		end else begin
			wb_res = wsetok_pkg::mk_res(wsetok_pkg::KIND_WORD_CHAR, c, '0);
			wb_mode = wsetok_pkg::MODE_WORD;
		end
	end

	// closing result of the open word
	always_comb begin
		if (kw_q && run_q == wsetok_pkg::KEYWORD_LEN) begin
			close_res = wsetok_pkg::mk_res(wsetok_pkg::KIND_KEYWORD_END, 8'd0, run_q);
		end else begin
			close_res = wsetok_pkg::mk_res(wsetok_pkg::KIND_IDENT_END, 8'd0, run_q);
		end
	end

	// a byte seen in idle; idle always holds run 0 and keyword match 1
	always_comb begin
		idle_emit = 1'b1;
		idle_mode = wsetok_pkg::MODE_IDLE;
		idle_run = '0;
		idle_kw = 1'b1;
		idle_res = wsetok_pkg::mk_res(wsetok_pkg::KIND_UNKNOWN, c, '0);
		if (is_space) begin
			idle_emit = 1'b0;
		end else if (c == wsetok_pkg::CH_EQUALS) begin
			idle_res = wsetok_pkg::mk_res(wsetok_pkg::KIND_EQUALS, c, '0);
		end else if (is_alpha) begin
			idle_res = wb_res;
			idle_mode = wb_mode;
			idle_run = wb_long ? '0 : wb_run;
			idle_kw = wb_long ? 1'b1 : wb_kw;
		end else if (c == wsetok_pkg::CH_QUOTE) begin
			idle_emit = 1'b0;
			idle_mode = wsetok_pkg::MODE_STR;
		end
	end

	// result selection and next state
	always_comb begin
		res[0] = wsetok_pkg::mk_res(wsetok_pkg::KIND_EOF, 8'd0, '0);
		res[1] = wsetok_pkg::mk_res(wsetok_pkg::KIND_EOF, 8'd0, '0);
		n_res = 2'd0;
		mode_d = mode_q;
		run_d = run_q;
		kw_d = kw_q;
		if (func) begin
			// end of text: close what is open, then the eof token
			mode_d = wsetok_pkg::MODE_IDLE;
			run_d = '0;
			kw_d = 1'b1;
			case (mode_q)
				wsetok_pkg::MODE_WORD: begin
					res[0] = close_res;
					n_res = 2'd2;
				end
				wsetok_pkg::MODE_STR: begin
					res[0] = wsetok_pkg::mk_res(wsetok_pkg::KIND_UNTERMINATED, 8'd0, run_q);
					n_res = 2'd2;
				end
				default: begin
					n_res = 2'd1;
				end
			endcase
		end else begin
			case (mode_q)
				wsetok_pkg::MODE_WORD: begin
					if (is_alpha || is_digit) begin
						res[0] = wb_res;
						n_res = 2'd1;
						mode_d = wb_mode;
						run_d = wb_long ? '0 : wb_run;
						kw_d = wb_long ? 1'b1 : wb_kw;
					end else begin
						// the word ends here, then the byte goes through idle handling
						res[0] = close_res;
						res[1] = idle_res;
						n_res = idle_emit ? 2'd2 : 2'd1;
						mode_d = idle_mode;
						run_d = idle_run;
						kw_d = idle_kw;
					end
				end
				wsetok_pkg::MODE_STR: begin
					n_res = 2'd1;
					if (c == wsetok_pkg::CH_QUOTE) begin
						res[0] = wsetok_pkg::mk_res(wsetok_pkg::KIND_STRING_END, 8'd0, run_q);
						mode_d = wsetok_pkg::MODE_IDLE;
						run_d = '0;
					end else begin
						res[0] = wsetok_pkg::mk_res(wsetok_pkg::KIND_STRING_CHAR, c, '0);
						if (run_q < wsetok_pkg::LEN_MAX) begin
							run_d = run_q + 1'b1;
						end
					end
				end
				default: begin
					res[0] = idle_res;
					n_res = idle_emit ? 2'd1 : 2'd0;
					mode_d = idle_mode;
					run_d = idle_run;
					kw_d = idle_kw;
				end
			endcase
		end
		// mark the last result of this request
		case (n_res)
			2'd1: res[0].last = 1'b1;
			2'd2: res[1].last = 1'b1;
			default: ;
		endcase
	end

	assign s_tready = (count_q <= 3'd2);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = (count_q != 3'd0);
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= wsetok_pkg::MODE_IDLE;
			run_q <= '0;
			kw_q <= 1'b1;
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q <= 3'd0;
		end else begin
			if (accept) begin
				mode_q <= mode_d;
				run_q <= run_d;
				kw_q <= kw_d;
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (accept ? {1'b0, n_res} : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	// queue payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res[0];
		end
		if (accept && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= res[1];
		end
	end

	assign m_tdata = {4'd0, fifo_q[rd_ptr_q].len, fifo_q[rd_ptr_q].value};
	assign m_tuser = fifo_q[rd_ptr_q].kind;
	assign m_tlast = fifo_q[rd_ptr_q].last;

endmodule

>>> hw/rtl/wsetok_checker.sv
module wsetok_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// eof is always the last result of its request
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == wsetok_pkg::KIND_EOF |-> m_tlast)
		else $error("eof without last");

	// byte kinds carry no length
	a_char_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == wsetok_pkg::KIND_WORD_CHAR ||
			m_tuser == wsetok_pkg::KIND_STRING_CHAR || m_tuser == wsetok_pkg::KIND_EQUALS ||
			m_tuser == wsetok_pkg::KIND_UNKNOWN) |-> m_tdata[23:8] == 16'd0)
		else $error("length on byte kind");

	// end kinds carry no byte
	a_end_val: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == wsetok_pkg::KIND_IDENT_END ||
			m_tuser == wsetok_pkg::KIND_KEYWORD_END || m_tuser == wsetok_pkg::KIND_STRING_END ||
			m_tuser == wsetok_pkg::KIND_UNTERMINATED || m_tuser == wsetok_pkg::KIND_TOO_LONG)
		|-> m_tdata[7:0] == 8'd0 && m_tdata[23:20] == 4'd0)
		else $error("byte on end kind");

	// a keyword end always reports the keyword length
	a_kw_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == wsetok_pkg::KIND_KEYWORD_END
		|-> m_tdata[19:8] == wsetok_pkg::KEYWORD_LEN)
		else $error("keyword end with wrong length");

endmodule

bind word_string_equals_tokenizer wsetok_checker u_wsetok_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
